// ===== src/cqtr_pkg.sv =====
// ----------------------------------------------------------------------------
// cqtr_pkg
// Shared types, constants and helper functions of the cube quadtree tile
// residency block.
// ----------------------------------------------------------------------------
package cqtr_pkg;

   localparam int MAX_TREE_LEVEL_DEF = 6;
   localparam int FRAME_BITS_DEF     = 32;
   localparam int FACE_COUNT         = 6;
   localparam int OFFSET_W           = 20;
   localparam int CSR_AW             = 3;

   localparam logic [CSR_AW-1:0] CSR_ADDR_BASE_SPLIT = 3'd0;
   localparam logic [CSR_AW-1:0] CSR_ADDR_GRACE      = 3'd4;
   localparam logic [2:0]        BASE_SPLIT_MAX      = 3'd4;
   localparam logic [31:0]       GRACE_RESET         = 32'd60;

   typedef enum logic [1:0] {
      MODE_ADD      = 2'd0,
      MODE_LOOKUP   = 2'd1,
      MODE_COMPLETE = 2'd2,
      MODE_PURGE    = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_NOTLOADED = 2'd0,
      ST_LOADING   = 2'd1,
      ST_LOADED    = 2'd2,
      ST_FAILED    = 2'd3
   } tile_state_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DISP,
      S_ADD_RD,
      S_ADD_WR,
      S_LK_RD,
      S_LK_CHK,
      S_LK_WR_EX,
      S_LK_WR_RES,
      S_CP_RD,
      S_CP_WR,
      S_PG_RD,
      S_PG_WR,
      S_DONE
   } eng_state_type;

   typedef struct packed {
      logic [2:0]  base_split;
      logic [31:0] grace_frames;
   } cfg_type;

   typedef struct packed {
      mode_type    mode;
      logic [2:0]  face;
      logic [3:0]  level;
      logic [18:0] coord_i;
      logic [18:0] coord_j;
      logic        load_ok;
      logic [31:0] frame;
   } item_type;

   typedef struct packed {
      logic        hit;
      logic [3:0]  res_level;
      logic [4:0]  level_diff;
      logic [18:0] off_u;
      logic [18:0] off_v;
      logic        request_valid;
      logic [3:0]  req_level;
      logic [7:0]  req_i;
      logic [7:0]  req_j;
      logic [14:0] evicted_count;
      logic        accepted;
   } result_type;

   // Index of the first node of tree level d inside one face: (4^d - 1) / 3.
   function automatic logic [OFFSET_W-1:0] level_offset(input logic [3:0] d);
      logic [OFFSET_W-1:0] r;
      r = '0;
      for (int k = 0; k < 9; k++) begin
         if (4'(k) < d) begin
            r = r | (OFFSET_W'(1) << (2 * k));
         end
      end
      return r;
   endfunction

   // Interleaves two 8-bit tile indices, i in the even bits and j in the odd.
   function automatic logic [15:0] morton(input logic [7:0] pi, input logic [7:0] pj);
      logic [15:0] m;
      m = '0;
      for (int b = 0; b < 8; b++) begin
         m[2*b]   = pi[b];
         m[2*b+1] = pj[b];
      end
      return m;
   endfunction

endpackage

// ===== src/cqtr_if.sv =====
// ----------------------------------------------------------------------------
// cqtr_req_if / cqtr_rsp_if
// Valid/ready channels for the request and result items.
// ----------------------------------------------------------------------------
interface cqtr_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [2:0]  face;
   logic [3:0]  level;
   logic [18:0] coord_i;
   logic [18:0] coord_j;
   logic        load_ok;
   logic [31:0] frame;

   modport source (output valid, mode, face, level, coord_i, coord_j, load_ok, frame,
                   input ready);
   modport sink (input valid, mode, face, level, coord_i, coord_j, load_ok, frame,
                 output ready);
endinterface

interface cqtr_rsp_if;
   logic        valid;
   logic        ready;
   logic        hit;
   logic [3:0]  res_level;
   logic [4:0]  level_diff;
   logic [18:0] off_u;
   logic [18:0] off_v;
   logic        request_valid;
   logic [3:0]  req_level;
   logic [7:0]  req_i;
   logic [7:0]  req_j;
   logic [14:0] evicted_count;
   logic        accepted;

   modport source (output valid, hit, res_level, level_diff, off_u, off_v, request_valid,
                   req_level, req_i, req_j, evicted_count, accepted,
                   input ready);
   modport sink (input valid, hit, res_level, level_diff, off_u, off_v, request_valid,
                 req_level, req_i, req_j, evicted_count, accepted,
                 output ready);
endinterface

// ===== src/cube_quadtree_tile_residency_top.sv =====
// ----------------------------------------------------------------------------
// cube_quadtree_tile_residency_top
// Residency table for six cube-face quadtrees held in a node memory.
// ----------------------------------------------------------------------------
// Per request, add reads and writes back each node from the root down to
// its tree level, lookup reads each level it walks and may then write back the
// requested and the resident node, completion reads and may write back one
// node, and purge reads every node and writes back those it evicts. One
// request is in work at a time. After reset a clearing pass writes every
// node record, one per cycle; no request is taken until it ends.
module cube_quadtree_tile_residency_top #(
   parameter int MAX_TREE_LEVEL = cqtr_pkg::MAX_TREE_LEVEL_DEF,
   parameter int FRAME_BITS     = cqtr_pkg::FRAME_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   cqtr_req_if.sink                    req_ch,
   cqtr_rsp_if.source                  rsp_ch,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [cqtr_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);

   cqtr_pkg::cfg_type    cfg;
   cqtr_pkg::item_type   item;
   cqtr_pkg::result_type result;

   assign item.mode    = cqtr_pkg::mode_type'(req_ch.mode);
   assign item.face    = req_ch.face;
   assign item.level   = req_ch.level;
   assign item.coord_i = req_ch.coord_i;
   assign item.coord_j = req_ch.coord_j;
   assign item.load_ok = req_ch.load_ok;
   assign item.frame   = req_ch.frame;

   cqtr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   cqtr_engine #(
      .MAX_TREE_LEVEL (MAX_TREE_LEVEL),
      .FRAME_BITS     (FRAME_BITS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .req_item  (item),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .rsp_item  (result)
   );

   assign rsp_ch.hit           = result.hit;
   assign rsp_ch.res_level     = result.res_level;
   assign rsp_ch.level_diff    = result.level_diff;
   assign rsp_ch.off_u         = result.off_u;
   assign rsp_ch.off_v         = result.off_v;
   assign rsp_ch.request_valid = result.request_valid;
   assign rsp_ch.req_level     = result.req_level;
   assign rsp_ch.req_i         = result.req_i;
   assign rsp_ch.req_j         = result.req_j;
   assign rsp_ch.evicted_count = result.evicted_count;
   assign rsp_ch.accepted      = result.accepted;

endmodule

// ===== src/cqtr_ram.sv =====
// ----------------------------------------------------------------------------
// cqtr_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module cqtr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/cqtr_csr.sv =====
// ----------------------------------------------------------------------------
// cqtr_csr
// APB-style register file holding base_split and grace_frames.
// ----------------------------------------------------------------------------
module cqtr_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [cqtr_pkg::CSR_AW-1:0] paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready,
   output cqtr_pkg::cfg_type           cfg
);

   logic [2:0]  split_ff, split_in;
   logic [31:0] grace_ff, grace_in;
   logic        wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_comb begin
      split_in = split_ff;
      grace_in = grace_ff;
      if (wr_en) begin
         case (paddr)
            cqtr_pkg::CSR_ADDR_BASE_SPLIT: begin
               split_in = (pwdata[2:0] > cqtr_pkg::BASE_SPLIT_MAX) ?
                          cqtr_pkg::BASE_SPLIT_MAX : pwdata[2:0];
            end
            cqtr_pkg::CSR_ADDR_GRACE: begin
               grace_in = pwdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         split_ff <= '0;
         grace_ff <= cqtr_pkg::GRACE_RESET;
      end else begin
         split_ff <= split_in;
         grace_ff <= grace_in;
      end
   end

   always_comb begin
      case (paddr)
         cqtr_pkg::CSR_ADDR_BASE_SPLIT: prdata = {29'd0, split_ff};
         cqtr_pkg::CSR_ADDR_GRACE:      prdata = grace_ff;
         default:                       prdata = '0;
      endcase
   end

   assign cfg.base_split   = split_ff;
   assign cfg.grace_frames = grace_ff;

endmodule

// ===== src/cqtr_engine.sv =====
// ----------------------------------------------------------------------------
// cqtr_engine
// Sequencer that reads, modifies and writes back the node table for add,
// lookup, completion and purge, plus the result register.
// ----------------------------------------------------------------------------
module cqtr_engine #(
   parameter int MAX_TREE_LEVEL = cqtr_pkg::MAX_TREE_LEVEL_DEF,
   parameter int FRAME_BITS     = cqtr_pkg::FRAME_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cqtr_pkg::cfg_type      cfg,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  cqtr_pkg::item_type     req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output cqtr_pkg::result_type   rsp_item
);

   localparam int L   = MAX_TREE_LEVEL;
   localparam int NPF = ((1 << (2 * (L + 1))) - 1) / 3;
   localparam int NT  = cqtr_pkg::FACE_COUNT * NPF;
   localparam int AW  = $clog2(NT);
   localparam int SW  = $clog2(NPF);
   localparam int MW  = 2 * L;
   localparam int RW  = FRAME_BITS + 4;
   localparam int GW  = (FRAME_BITS > 32) ? FRAME_BITS : 32;

   cqtr_pkg::eng_state_type state_ff, state_in;
   cqtr_pkg::item_type      op_ff, op_in;
   logic [4:0]              tl_ff, tl_in;
   logic [3:0]              d_ff, d_in;
   logic [3:0]              lim_ff, lim_in;
   logic [AW-1:0]           addr_ff, addr_in;
   logic                    have_ex_ff, have_ex_in, have_res_ff, have_res_in;
   logic [3:0]              ex_lvl_ff, ex_lvl_in, res_lvl_ff, res_lvl_in;
   logic [AW-1:0]           ex_addr_ff, ex_addr_in, res_addr_ff, res_addr_in;
   logic [RW-1:0]           ex_rec_ff, ex_rec_in, res_rec_ff, res_rec_in;
   logic [2:0]              pf_ff, pf_in;
   logic [3:0]              pl_ff, pl_in;
   logic [MW-1:0]           pm_ff, pm_in;
   logic                    acc_ff, acc_in;
   logic [14:0]             cnt_ff, cnt_in;
   logic [AW-1:0]           clr_ff, clr_in;
   cqtr_pkg::result_type    rsl_ff, rsl_in;
   cqtr_pkg::result_type    out_ff, out_in;
   logic                    ovalid_ff, ovalid_in;

   // Table and subtree-flag memory ports.
   logic          tbl_we, tbl_re;
   logic [AW-1:0] tbl_waddr, tbl_raddr;
   logic [RW-1:0] tbl_wdata, tbl_rdata;
   logic          sub_we, sub_re;
   logic [SW-1:0] sub_waddr, sub_raddr;
   logic          sub_wdata, sub_rdata;

   cqtr_ram #(.WIDTH(RW), .DEPTH(NT)) u_table (
      .clock (clock),
      .we    (tbl_we),
      .waddr (tbl_waddr),
      .wdata (tbl_wdata),
      .re    (tbl_re),
      .raddr (tbl_raddr),
      .rdata (tbl_rdata)
   );

   cqtr_ram #(.WIDTH(1), .DEPTH(NPF)) u_subtree (
      .clock (clock),
      .we    (sub_we),
      .waddr (sub_waddr),
      .wdata (sub_wdata),
      .re    (sub_re),
      .raddr (sub_raddr),
      .rdata (sub_rdata)
   );

   // Address generation shared by every read.
   logic [FRAME_BITS-1:0]    now_fb;
   logic [4:0]               walk_sh;
   logic [18:0]              pi_full, pj_full;
   logic [15:0]              mort16;
   logic                     use_purge;
   logic [2:0]               g_face;
   logic [3:0]               g_d;
   logic [MW-1:0]            g_m;
   logic [cqtr_pkg::OFFSET_W-1:0] g_off, p_off;
   logic [SW-1:0]            g_local, p_local;
   logic [AW-1:0]            g_addr;

   assign now_fb    = FRAME_BITS'(op_ff.frame);
   assign walk_sh   = tl_ff - {1'b0, d_ff};
   assign pi_full   = op_ff.coord_i >> walk_sh;
   assign pj_full   = op_ff.coord_j >> walk_sh;
   assign mort16    = cqtr_pkg::morton(pi_full[7:0], pj_full[7:0]);
   assign use_purge = (state_ff == cqtr_pkg::S_PG_RD);
   assign g_face    = use_purge ? pf_ff : op_ff.face;
   assign g_d       = use_purge ? pl_ff : d_ff;
   assign g_m       = use_purge ? pm_ff : mort16[MW-1:0];
   assign g_off     = cqtr_pkg::level_offset(g_d);
   assign g_local   = g_off[SW-1:0] + SW'(g_m);
   assign g_addr    = AW'(g_face) * AW'(NPF) + AW'(g_local);
   assign p_off     = cqtr_pkg::level_offset(pl_ff - 4'd1);
   assign p_local   = p_off[SW-1:0] + SW'(pm_ff >> 2);

   // Fields of the record just read.
   logic                  r_node, r_tile, r_present, r_stale;
   logic [1:0]            r_st;
   logic [FRAME_BITS-1:0] r_frame, age;

   assign r_node  = tbl_rdata[0];
   assign r_tile  = tbl_rdata[1];
   assign r_st    = tbl_rdata[3:2];
   assign r_frame = tbl_rdata[RW-1:4];
   assign age     = now_fb - r_frame;
   assign r_stale = GW'(age) > GW'(cfg.grace_frames);

   // Dispatch checks on the captured request.
   logic [4:0]  tl_calc;
   logic        add_oor, lk_oor, cp_oor;
   logic [18:0] sh_ci, sh_cj, lv_ci, lv_cj;

   assign tl_calc = {1'b0, op_ff.level} + {2'b00, cfg.base_split};
   assign sh_ci   = op_ff.coord_i >> tl_calc;
   assign sh_cj   = op_ff.coord_j >> tl_calc;
   assign lv_ci   = op_ff.coord_i >> op_ff.level;
   assign lv_cj   = op_ff.coord_j >> op_ff.level;
   assign lk_oor  = (sh_ci != '0) || (sh_cj != '0);
   assign add_oor = (tl_calc > 5'(L)) || lk_oor;
   assign cp_oor  = ({1'b0, op_ff.level} > 5'(L)) || (lv_ci != '0) || (lv_cj != '0);

   // Lookup result arithmetic.
   logic [4:0]  ex_sh, res_diff;
   logic [18:0] ex_i, ex_j, off_mask;

   assign ex_sh    = tl_ff - {1'b0, ex_lvl_ff};
   assign ex_i     = op_ff.coord_i >> ex_sh;
   assign ex_j     = op_ff.coord_j >> ex_sh;
   assign res_diff = tl_ff - {1'b0, res_lvl_ff};
   assign off_mask = ~(19'h7FFFF << res_diff);

   // Purge node evaluation.
   logic          pg_present, pg_child, pg_sub, pg_evict;
   logic [4:0]    next_sh;
   logic [3:0]    next_l;
   logic [MW-1:0] ones_m;

   assign pg_present = r_node || (pl_ff == 4'd0);
   assign pg_child   = (pl_ff < 4'(L)) ? sub_rdata : 1'b0;
   assign pg_evict   = pg_present && r_tile && (r_st == cqtr_pkg::ST_LOADED) &&
                       !pg_child && r_stale;
   assign pg_sub     = pg_present &&
                       (pg_child || (r_tile && (r_st == cqtr_pkg::ST_LOADED) && !pg_evict));
   assign ones_m     = '1;
   assign next_l     = pl_ff - 4'd1;
   assign next_sh    = 5'(MW) - {next_l, 1'b0};

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      tl_in       = tl_ff;
      d_in        = d_ff;
      lim_in      = lim_ff;
      addr_in     = addr_ff;
      have_ex_in  = have_ex_ff;
      have_res_in = have_res_ff;
      ex_lvl_in   = ex_lvl_ff;
      res_lvl_in  = res_lvl_ff;
      ex_addr_in  = ex_addr_ff;
      res_addr_in = res_addr_ff;
      ex_rec_in   = ex_rec_ff;
      res_rec_in  = res_rec_ff;
      pf_in       = pf_ff;
      pl_in       = pl_ff;
      pm_in       = pm_ff;
      acc_in      = acc_ff;
      cnt_in      = cnt_ff;
      clr_in      = clr_ff;
      rsl_in      = rsl_ff;
      out_in      = out_ff;
      ovalid_in   = ovalid_ff;
      req_ready   = 1'b0;
      tbl_we      = 1'b0;
      tbl_waddr   = addr_ff;
      tbl_wdata   = tbl_rdata;
      tbl_re      = 1'b0;
      tbl_raddr   = g_addr;
      sub_we      = 1'b0;
      sub_waddr   = p_local;
      sub_wdata   = acc_ff || pg_sub;
      sub_re      = 1'b0;
      sub_raddr   = g_local;

      if (ovalid_ff && rsp_ready) begin
         ovalid_in = 1'b0;
      end

      case (state_ff)
         cqtr_pkg::S_CLEAR: begin
            tbl_we    = 1'b1;
            tbl_waddr = clr_ff;
            tbl_wdata = '0;
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == AW'(NT - 1)) begin
               state_in = cqtr_pkg::S_IDLE;
            end
         end
         cqtr_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in    = req_item;
               state_in = cqtr_pkg::S_DISP;
            end
         end
         cqtr_pkg::S_DISP: begin
            rsl_in      = '0;
            have_ex_in  = 1'b0;
            have_res_in = 1'b0;
            d_in        = 4'd0;
            tl_in       = tl_calc;
            lim_in      = (tl_calc < 5'(L)) ? tl_calc[3:0] : 4'(L);
            state_in    = cqtr_pkg::S_DONE;
            if (op_ff.mode == cqtr_pkg::MODE_PURGE) begin
               pf_in    = 3'(cqtr_pkg::FACE_COUNT - 1);
               pl_in    = 4'(L);
               pm_in    = ones_m;
               acc_in   = 1'b0;
               cnt_in   = '0;
               state_in = cqtr_pkg::S_PG_RD;
            end else if (op_ff.face < 3'(cqtr_pkg::FACE_COUNT)) begin
               case (op_ff.mode)
                  cqtr_pkg::MODE_ADD: begin
                     if (!add_oor) begin
                        state_in = cqtr_pkg::S_ADD_RD;
                     end
                  end
                  cqtr_pkg::MODE_LOOKUP: begin
                     if (!lk_oor) begin
                        state_in = cqtr_pkg::S_LK_RD;
                     end
                  end
                  default: begin
                     // Completion addresses the tree level directly.
                     tl_in = {1'b0, op_ff.level};
                     d_in  = op_ff.level;
                     if (!cp_oor) begin
                        state_in = cqtr_pkg::S_CP_RD;
                     end
                  end
               endcase
            end
         end
         cqtr_pkg::S_ADD_RD: begin
            tbl_re   = 1'b1;
            addr_in  = g_addr;
            state_in = cqtr_pkg::S_ADD_WR;
         end
         cqtr_pkg::S_ADD_WR: begin
            tbl_we    = 1'b1;
            tbl_wdata = tbl_rdata | RW'(1);
            if ({1'b0, d_ff} == tl_ff) begin
               if (!r_tile) begin
                  tbl_wdata       = RW'(3);
                  rsl_in.accepted = 1'b1;
               end
               state_in = cqtr_pkg::S_DONE;
            end else begin
               d_in     = d_ff + 4'd1;
               state_in = cqtr_pkg::S_ADD_RD;
            end
         end
         cqtr_pkg::S_LK_RD: begin
            tbl_re   = 1'b1;
            addr_in  = g_addr;
            state_in = cqtr_pkg::S_LK_CHK;
         end
         cqtr_pkg::S_LK_CHK: begin
            if (!(r_node || (d_ff == 4'd0))) begin
               state_in = cqtr_pkg::S_LK_WR_EX;
            end else begin
               if (r_tile) begin
                  have_ex_in = 1'b1;
                  ex_lvl_in  = d_ff;
                  ex_addr_in = addr_ff;
                  ex_rec_in  = tbl_rdata;
                  if (r_st == cqtr_pkg::ST_LOADED) begin
                     have_res_in = 1'b1;
                     res_lvl_in  = d_ff;
                     res_addr_in = addr_ff;
                     res_rec_in  = tbl_rdata;
                  end
               end
               if (d_ff == lim_ff) begin
                  state_in = cqtr_pkg::S_LK_WR_EX;
               end else begin
                  d_in     = d_ff + 4'd1;
                  state_in = cqtr_pkg::S_LK_RD;
               end
            end
         end
         cqtr_pkg::S_LK_WR_EX: begin
            tbl_waddr = ex_addr_ff;
            tbl_wdata = {ex_rec_ff[RW-1:4], cqtr_pkg::ST_LOADING, ex_rec_ff[1:0]};
            state_in  = cqtr_pkg::S_LK_WR_RES;
            if (!have_ex_ff) begin
               state_in = cqtr_pkg::S_DONE;
            end else if (ex_rec_ff[3:2] == cqtr_pkg::ST_NOTLOADED) begin
               tbl_we               = 1'b1;
               rsl_in.request_valid = 1'b1;
               rsl_in.req_level     = ex_lvl_ff;
               rsl_in.req_i         = ex_i[7:0];
               rsl_in.req_j         = ex_j[7:0];
            end
         end
         cqtr_pkg::S_LK_WR_RES: begin
            tbl_waddr = res_addr_ff;
            tbl_wdata = {now_fb, res_rec_ff[3:0]};
            state_in  = cqtr_pkg::S_DONE;
            if (have_res_ff) begin
               tbl_we            = 1'b1;
               rsl_in.hit        = 1'b1;
               rsl_in.res_level  = res_lvl_ff;
               rsl_in.level_diff = res_diff;
               rsl_in.off_u      = op_ff.coord_i & off_mask;
               rsl_in.off_v      = op_ff.coord_j & off_mask;
            end
         end
         cqtr_pkg::S_CP_RD: begin
            tbl_re   = 1'b1;
            addr_in  = g_addr;
            state_in = cqtr_pkg::S_CP_WR;
         end
         cqtr_pkg::S_CP_WR: begin
            state_in = cqtr_pkg::S_DONE;
            if (r_tile && (r_st == cqtr_pkg::ST_LOADING)) begin
               tbl_we          = 1'b1;
               rsl_in.accepted = 1'b1;
               if (op_ff.load_ok) begin
                  tbl_wdata = {now_fb, cqtr_pkg::ST_LOADED, tbl_rdata[1:0]};
               end else begin
                  tbl_wdata = {r_frame, cqtr_pkg::ST_FAILED, tbl_rdata[1:0]};
               end
            end
         end
         cqtr_pkg::S_PG_RD: begin
            tbl_re   = 1'b1;
            sub_re   = 1'b1;
            addr_in  = g_addr;
            state_in = cqtr_pkg::S_PG_WR;
         end
         cqtr_pkg::S_PG_WR: begin
            // Nodes go deepest level first, so children are settled before
            // their parent; each group of four siblings leaves one flag.
            if (pg_evict) begin
               tbl_we    = 1'b1;
               tbl_wdata = {r_frame, cqtr_pkg::ST_NOTLOADED, tbl_rdata[1:0]};
               cnt_in    = cnt_ff + 15'd1;
            end
            if (pm_ff[1:0] == 2'b00) begin
               acc_in = 1'b0;
               sub_we = (pl_ff != 4'd0);
            end else begin
               acc_in = acc_ff || pg_sub;
            end
            state_in = cqtr_pkg::S_PG_RD;
            if (pm_ff != '0) begin
               pm_in = pm_ff - MW'(1);
            end else if (pl_ff != 4'd0) begin
               pl_in = next_l;
               pm_in = ones_m >> next_sh;
            end else if (pf_ff != 3'd0) begin
               pf_in = pf_ff - 3'd1;
               pl_in = 4'(L);
               pm_in = ones_m;
            end else begin
               state_in = cqtr_pkg::S_DONE;
            end
            rsl_in.evicted_count = cnt_in;
         end
         cqtr_pkg::S_DONE: begin
            if (!ovalid_ff || rsp_ready) begin
               out_in    = rsl_ff;
               ovalid_in = 1'b1;
               state_in  = cqtr_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = cqtr_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= cqtr_pkg::S_CLEAR;
         clr_ff    <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      tl_ff       <= tl_in;
      d_ff        <= d_in;
      lim_ff      <= lim_in;
      addr_ff     <= addr_in;
      have_ex_ff  <= have_ex_in;
      have_res_ff <= have_res_in;
      ex_lvl_ff   <= ex_lvl_in;
      res_lvl_ff  <= res_lvl_in;
      ex_addr_ff  <= ex_addr_in;
      res_addr_ff <= res_addr_in;
      ex_rec_ff   <= ex_rec_in;
      res_rec_ff  <= res_rec_in;
      pf_ff       <= pf_in;
      pl_ff       <= pl_in;
      pm_ff       <= pm_in;
      acc_ff      <= acc_in;
      cnt_ff      <= cnt_in;
      rsl_ff      <= rsl_in;
      out_ff      <= out_in;
   end

   assign rsp_valid = ovalid_ff;
   assign rsp_item  = out_ff;

`ifndef NO_ASSERTIONS
   a_no_request_while_clearing: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cqtr_pkg::S_CLEAR) |-> !req_ready)
      else $error("request taken during table clearing pass");

   a_no_same_entry_overlap: assert property (@(posedge clock) disable iff (reset)
      !(tbl_we && tbl_re && (tbl_waddr == tbl_raddr)))
      else $error("table read and write hit the same entry in one cycle");

   a_subtree_write_has_parent: assert property (@(posedge clock) disable iff (reset)
      sub_we |-> ((state_ff == cqtr_pkg::S_PG_WR) && (pl_ff != 4'd0)))
      else $error("subtree flag written outside a purge or for a root");

   a_result_held_until_taken: assert property (@(posedge clock) disable iff (reset)
      (ovalid_ff && !rsp_ready) |=> (ovalid_ff && $stable(out_ff)))
      else $error("pending result changed before it was taken");
`endif

endmodule
